FILE: rtl/olm_pkg.sv
// Shared constants and codes for the ordered list with middle operations.
// No dependencies; imported by the core.
`default_nettype none

package olm_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned VW    = 32;

  // Output tdata: removed_value then entry_count, padded to whole bytes
  localparam int unsigned OUT_DW = ((VW + CW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_APPEND     = 2'd0,
    CMD_POP_HEAD   = 2'd1,
    CMD_INSERT_MID = 2'd2,
    CMD_REMOVE_MID = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/ordered_list_with_middle_ops_core.sv
// Ordered list store: tail append, head removal, middle insert and remove.
// Uses olm_pkg for sizes and command/status codes.
//
// Channel   Dir  tdata (low bit up)                    tuser (low bit up)
// s_axis    in   value[31:0]                           command[1:0]
// m_axis    out  removed_value[31:0], entry_count[6:0] removed_valid, status[1:0]
//
// Entries sit in a single-port-write, registered-read memory; each word moves
// by a read then a write state. With n entries held and p the target, insert
// moves n-p words tailward, then writes at p; remove reads p, then moves n-1-p
// words headward. Rejected commands (empty or full) give their beat next cycle.
// The slave side is ready only between commands; a stalled result holds.
// Reset clears the count and control; the memory is not cleared.
`default_nettype none

module ordered_list_with_middle_ops_core
  import olm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [VW-1:0]     s_axis_tdata,   // value
  input  wire logic [1:0]        s_axis_tuser,   // command
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_DW-1:0]      m_axis_tdata,   // removed_value, entry_count, zero pad
  output logic [2:0]             m_axis_tuser    // removed_valid, status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_WR,
    S_REM_RD,
    S_REM_CAP,
    S_REM_CHK,
    S_REM_WR,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [AW-1:0]   idx_q;
  logic [AW-1:0]   pos_q;
  logic [VW-1:0]   val_q;
  logic [VW-1:0]   removed_q;
  logic            rvalid_q;
  status_e         status_q;

  logic [VW-1:0]   mem [DEPTH];
  logic [VW-1:0]   rdata_q;

  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [VW-1:0]   mem_wdata;
  logic            rem_last;
  logic            accept;
  cmd_e            cmd;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cmd      = cmd_e'(s_axis_tuser);
  assign rem_last = (CW'(idx_q) + CW'(1)) >= count_q;

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rdata_q;
    unique case (state_q)
      S_INS_CHK: begin
        if (idx_q == pos_q) begin
          mem_we    = 1'b1;
          mem_wdata = val_q;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - AW'(1);
        end
      end
      S_INS_WR: mem_we = 1'b1;
      S_REM_RD: mem_re = 1'b1;
      S_REM_CHK: begin
        if (!rem_last) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + AW'(1);
        end
      end
      S_REM_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      val_q     <= '0;
      removed_q <= '0;
      rvalid_q  <= 1'b0;
      status_q  <= ST_DONE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q     <= s_axis_tdata;
            removed_q <= '0;
            rvalid_q  <= 1'b0;
            status_q  <= ST_DONE;
            case (cmd) inside
              CMD_APPEND, CMD_INSERT_MID: begin
                if (count_q >= CW'(DEPTH)) begin
                  status_q <= ST_FULL;
                  state_q  <= S_OUT;
                end else begin
                  idx_q <= AW'(count_q);
                  if (cmd == CMD_INSERT_MID && count_q >= CW'(2)) begin
                    pos_q <= AW'(count_q >> 1);
                  end else begin
                    pos_q <= AW'(count_q);
                  end
                  state_q <= S_INS_CHK;
                end
              end
              default: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_OUT;
                end else begin
                  if (cmd == CMD_REMOVE_MID && count_q > CW'(2)) begin
                    idx_q <= AW'(count_q >> 1);
                  end else begin
                    idx_q <= '0;
                  end
                  state_q <= S_REM_RD;
                end
              end
            endcase
          end
        end
        S_INS_CHK: begin
          if (idx_q == pos_q) begin
            count_q <= count_q + CW'(1);
            state_q <= S_OUT;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          // shift one word toward the tail, then step down
          idx_q   <= idx_q - AW'(1);
          state_q <= S_INS_CHK;
        end
        S_REM_RD: state_q <= S_REM_CAP;
        S_REM_CAP: begin
          removed_q <= rdata_q;
          state_q   <= S_REM_CHK;
        end
        S_REM_CHK: begin
          if (rem_last) begin
            count_q  <= count_q - CW'(1);
            rvalid_q <= 1'b1;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          // close the gap one word at a time
          idx_q   <= idx_q + AW'(1);
          state_q <= S_REM_CHK;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {{(OUT_DW - VW - CW){1'b0}}, count_q, removed_q};
  assign m_axis_tuser  = {status_q, rvalid_q};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_reject_no_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status_q != ST_DONE |-> !rvalid_q && removed_q == '0)
    else $error("rejected command reports a removed entry");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("slave ready while a result is pending");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rvalid_q && !$past(m_axis_tvalid) |-> $past(count_q) == count_q + CW'(1))
    else $error("removal did not lower the count by one");
`endif

endmodule

`default_nettype wire
